/* sv/tra_pkg.sv */
// ----------------------------------------------------------------------------
// tra_pkg: shared types and operation codes
// Operation encodings of the sixteen register-register ALU instructions and
// the result bundle that the ALU core hands to the top level.
// ----------------------------------------------------------------------------
package tra_pkg;

   typedef logic [3:0] cmd_type;

   localparam cmd_type OP_AND = 4'd0;
   localparam cmd_type OP_EOR = 4'd1;
   localparam cmd_type OP_LSL = 4'd2;
   localparam cmd_type OP_LSR = 4'd3;
   localparam cmd_type OP_ASR = 4'd4;
   localparam cmd_type OP_ADC = 4'd5;
   localparam cmd_type OP_SBC = 4'd6;
   localparam cmd_type OP_ROR = 4'd7;
   localparam cmd_type OP_TST = 4'd8;
   localparam cmd_type OP_NEG = 4'd9;
   localparam cmd_type OP_CMP = 4'd10;
   localparam cmd_type OP_CMN = 4'd11;
   localparam cmd_type OP_ORR = 4'd12;
   localparam cmd_type OP_MUL = 4'd13;
   localparam cmd_type OP_BIC = 4'd14;
   localparam cmd_type OP_MVN = 4'd15;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned INDEX_WIDTH = 3;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] result_value;
      logic                  write_back;
      logic                  flag_negative;
      logic                  flag_zero;
      logic                  flag_carry;
      logic                  flag_overflow;
   } result_type;

endpackage

/* sv/tra_alu_core.sv */
// ----------------------------------------------------------------------------
// tra_alu_core: combinational ALU datapath
// Adder, register-controlled shifter, multiplier and logic unit in parallel,
// followed by result and flag selection.
// ----------------------------------------------------------------------------
module tra_alu_core (
   input  tra_pkg::cmd_type                  command,
   input  logic [tra_pkg::DATA_WIDTH-1:0]    first_operand,
   input  logic [tra_pkg::DATA_WIDTH-1:0]    second_operand,
   input  logic                              carry_in,
   input  logic                              overflow_in,
   output tra_pkg::result_type               result
);

   logic [31:0] add_a;
   logic [31:0] add_b;
   logic        add_cin;
   logic [32:0] add_sum;
   logic        add_overflow;

   logic [7:0]  amount;
   logic [4:0]  amount_low;
   logic [32:0] lsl_wide;
   logic [32:0] lsr_wide;
   logic [32:0] asr_wide;
   logic [63:0] ror_wide;
   logic [31:0] shift_value;
   logic        shift_carry;

   logic [31:0] product;
   logic [31:0] value;
   logic        carry;
   logic        overflow;
   logic        write_back;

   // adder operand selection
   always_comb begin
      add_a   = first_operand;
      add_b   = second_operand;
      add_cin = carry_in;
      case (command)
         tra_pkg::OP_SBC: begin
            add_b = ~second_operand;
         end
         tra_pkg::OP_NEG: begin
            add_a   = '0;
            add_b   = ~second_operand;
            add_cin = 1'b1;
         end
         tra_pkg::OP_CMP: begin
            add_b   = ~second_operand;
            add_cin = 1'b1;
         end
         tra_pkg::OP_CMN: begin
            add_cin = 1'b0;
         end
         default: begin
            add_cin = carry_in;
         end
      endcase
   end

   assign add_sum      = {1'b0, add_a} + {1'b0, add_b} + {32'd0, add_cin};
   assign add_overflow = (add_a[31] ^ add_sum[31]) & (add_b[31] ^ add_sum[31]);

   // shifter: carry rides in an extra bit next to the value
   assign amount     = second_operand[7:0];
   assign amount_low = amount[4:0];
   assign lsl_wide   = {1'b0, first_operand} << amount_low;
   assign lsr_wide   = {first_operand, 1'b0} >> amount_low;
   assign asr_wide   = 33'($signed({first_operand, 1'b0}) >>> amount_low);
   assign ror_wide   = {first_operand, first_operand} >> amount_low;

   always_comb begin
      shift_value = first_operand;
      shift_carry = carry_in;
      if (amount != 8'd0) begin
         case (command)
            tra_pkg::OP_LSL: begin
               if (amount < 8'd32) begin
                  shift_value = lsl_wide[31:0];
                  shift_carry = lsl_wide[32];
               end else begin
                  shift_value = '0;
                  shift_carry = (amount == 8'd32) ? first_operand[0] : 1'b0;
               end
            end
            tra_pkg::OP_LSR: begin
               if (amount < 8'd32) begin
                  shift_value = lsr_wide[32:1];
                  shift_carry = lsr_wide[0];
               end else begin
                  shift_value = '0;
                  shift_carry = (amount == 8'd32) ? first_operand[31] : 1'b0;
               end
            end
            tra_pkg::OP_ASR: begin
               if (amount < 8'd32) begin
                  shift_value = asr_wide[32:1];
                  shift_carry = asr_wide[0];
               end else begin
                  shift_value = {32{first_operand[31]}};
                  shift_carry = first_operand[31];
               end
            end
            default: begin
               shift_value = ror_wide[31:0];
               shift_carry = ror_wide[31];
            end
         endcase
      end
   end

   assign product = first_operand * second_operand;

   // result and flag selection
   always_comb begin
      value      = first_operand & second_operand;
      carry      = carry_in;
      overflow   = overflow_in;
      write_back = 1'b1;
      case (command)
         tra_pkg::OP_AND: value = first_operand & second_operand;
         tra_pkg::OP_EOR: value = first_operand ^ second_operand;
         tra_pkg::OP_LSL, tra_pkg::OP_LSR, tra_pkg::OP_ASR, tra_pkg::OP_ROR: begin
            value = shift_value;
            carry = shift_carry;
         end
         tra_pkg::OP_ADC, tra_pkg::OP_SBC, tra_pkg::OP_NEG: begin
            value    = add_sum[31:0];
            carry    = add_sum[32];
            overflow = add_overflow;
         end
         tra_pkg::OP_CMP, tra_pkg::OP_CMN: begin
            value      = add_sum[31:0];
            carry      = add_sum[32];
            overflow   = add_overflow;
            write_back = 1'b0;
         end
         tra_pkg::OP_TST: begin
            value      = first_operand & second_operand;
            write_back = 1'b0;
         end
         tra_pkg::OP_ORR: value = first_operand | second_operand;
         tra_pkg::OP_MUL: value = product;
         tra_pkg::OP_BIC: value = first_operand & ~second_operand;
         default:         value = ~second_operand;
      endcase
   end

   assign result.result_value  = value;
   assign result.write_back    = write_back;
   assign result.flag_negative = value[31];
   assign result.flag_zero     = (value == 32'd0);
   assign result.flag_carry    = carry;
   assign result.flag_overflow = overflow;

endmodule

/* sv/thumb_register_alu_unit.sv */
// ----------------------------------------------------------------------------
// thumb_register_alu_unit: register-register ALU for the compressed ISA
// Executes the sixteen ALU-format operations (logic, shifts by register,
// add/subtract with carry, compares, multiply) and returns the result value,
// write-back enable, destination index and new N, Z, C and V flags.
//
// Usage:
//   Request channel (req_*): one transaction per instruction, accepted at a
//   rising edge with req_valid high and req_stall low.
//   Response channel (rsp_*): one transaction per request, in order, taken at
//   a rising edge with rsp_valid high and rsp_stall low.
//   Path: the request is captured in an input register; the ALU core
//   computes between that register and the result register, which holds
//   the response while rsp_valid is high.
//   Throughput: one transaction per cycle unless the receiver stalls; the ALU
//   core between the registers is combinational (longest path: 32x32 multiplier).
//   Stall: when the receiver stalls, the result register holds its
//   transaction; the input register still accepts one more request, and
//   req_stall rises only when both registers are full.
//   Reset: synchronous, active high; both stages empty, no state kept.
// ----------------------------------------------------------------------------
module thumb_register_alu_unit (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [3:0]                            req_command,
   input  logic [tra_pkg::DATA_WIDTH-1:0]        req_first_operand,
   input  logic [tra_pkg::DATA_WIDTH-1:0]        req_second_operand,
   input  logic                                  req_carry_in,
   input  logic                                  req_overflow_in,
   input  logic [tra_pkg::INDEX_WIDTH-1:0]       req_dest_index,

   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [tra_pkg::DATA_WIDTH-1:0]        rsp_result_value,
   output logic                                  rsp_write_back,
   output logic [tra_pkg::INDEX_WIDTH-1:0]       rsp_write_index,
   output logic                                  rsp_flag_negative,
   output logic                                  rsp_flag_zero,
   output logic                                  rsp_flag_carry,
   output logic                                  rsp_flag_overflow
);

   // input register stage
   logic                              stage_valid_ff, stage_valid_in;
   tra_pkg::cmd_type                  stage_command_ff, stage_command_in;
   logic [tra_pkg::DATA_WIDTH-1:0]    stage_first_ff, stage_first_in;
   logic [tra_pkg::DATA_WIDTH-1:0]    stage_second_ff, stage_second_in;
   logic                              stage_carry_ff, stage_carry_in;
   logic                              stage_overflow_ff, stage_overflow_in;
   logic [tra_pkg::INDEX_WIDTH-1:0]   stage_index_ff, stage_index_in;

   // result register stage
   logic                              out_valid_ff, out_valid_in;
   tra_pkg::result_type               out_result_ff, out_result_in;
   logic [tra_pkg::INDEX_WIDTH-1:0]   out_index_ff, out_index_in;

   tra_pkg::result_type               core_result;
   logic                              out_advance;
   logic                              req_accept;

   // The result register may load when it is empty or its transaction leaves now.
   assign out_advance = !out_valid_ff || !rsp_stall;
   // The input register is blocked only when it is full and cannot drain.
   assign req_stall   = stage_valid_ff && !out_advance;
   assign req_accept  = req_valid && !req_stall;

   tra_alu_core u_core (
      .command        (stage_command_ff),
      .first_operand  (stage_first_ff),
      .second_operand (stage_second_ff),
      .carry_in       (stage_carry_ff),
      .overflow_in    (stage_overflow_ff),
      .result         (core_result)
   );

   // input stage next values: load on accept, drop when drained, else hold
   always_comb begin
      stage_valid_in    = stage_valid_ff;
      stage_command_in  = stage_command_ff;
      stage_first_in    = stage_first_ff;
      stage_second_in   = stage_second_ff;
      stage_carry_in    = stage_carry_ff;
      stage_overflow_in = stage_overflow_ff;
      stage_index_in    = stage_index_ff;
      if (!req_stall) begin
         stage_valid_in = req_valid;
      end
      if (req_accept) begin
         stage_command_in  = req_command;
         stage_first_in    = req_first_operand;
         stage_second_in   = req_second_operand;
         stage_carry_in    = req_carry_in;
         stage_overflow_in = req_overflow_in;
         stage_index_in    = req_dest_index;
      end
   end

   // result stage next values: advance the computed transaction, else hold
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_result_in = out_result_ff;
      out_index_in  = out_index_ff;
      if (out_advance) begin
         out_valid_in = stage_valid_ff;
         if (stage_valid_ff) begin
            out_result_in = core_result;
            out_index_in  = stage_index_ff;
         end
      end
   end

   // control state: cleared at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         out_valid_ff   <= out_valid_in;
      end
   end

   // payload: no reset needed
   always_ff @(posedge clock) begin
      stage_command_ff  <= stage_command_in;
      stage_first_ff    <= stage_first_in;
      stage_second_ff   <= stage_second_in;
      stage_carry_ff    <= stage_carry_in;
      stage_overflow_ff <= stage_overflow_in;
      stage_index_ff    <= stage_index_in;
      out_result_ff     <= out_result_in;
      out_index_ff      <= out_index_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_value  = out_result_ff.result_value;
   assign rsp_write_back    = out_result_ff.write_back;
   assign rsp_write_index   = out_index_ff;
   assign rsp_flag_negative = out_result_ff.flag_negative;
   assign rsp_flag_zero     = out_result_ff.flag_zero;
   assign rsp_flag_carry    = out_result_ff.flag_carry;
   assign rsp_flag_overflow = out_result_ff.flag_overflow;

endmodule

/* tb/sv/thumb_register_alu_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thumb_register_alu_checker: response predictor and scoreboard
// Watches both channels of the register ALU, works out the value, write-back
// and flags of every accepted request, and compares them in order against
// the responses.
// ----------------------------------------------------------------------------
module thumb_register_alu_checker
   import tra_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,

   input  logic                   req_valid,
   input  logic                   req_stall,
   input  logic [3:0]             req_command,
   input  logic [DATA_WIDTH-1:0]  req_first_operand,
   input  logic [DATA_WIDTH-1:0]  req_second_operand,
   input  logic                   req_carry_in,
   input  logic                   req_overflow_in,
   input  logic [INDEX_WIDTH-1:0] req_dest_index,

   input  logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  logic [DATA_WIDTH-1:0]  rsp_result_value,
   input  logic                   rsp_write_back,
   input  logic [INDEX_WIDTH-1:0] rsp_write_index,
   input  logic                   rsp_flag_negative,
   input  logic                   rsp_flag_zero,
   input  logic                   rsp_flag_carry,
   input  logic                   rsp_flag_overflow,

   output int unsigned            mismatch_count,
   output int unsigned            outstanding_count
);

   typedef struct packed {
      logic [DATA_WIDTH-1:0]  value;
      logic                   write_back;
      logic [INDEX_WIDTH-1:0] write_index;
      logic                   negative;
      logic                   zero;
      logic                   carry;
      logic                   overflow;
   } alu_outcome_t;

   alu_outcome_t predicted_results[$];
   int unsigned  response_number;

   // {overflow, carry, sum}
   function automatic logic [DATA_WIDTH+1:0] add_with_flags(
      input logic [DATA_WIDTH-1:0] a,
      input logic [DATA_WIDTH-1:0] b,
      input logic                  cin
   );
      logic [DATA_WIDTH:0]   wide;
      logic [DATA_WIDTH-1:0] sum;
      wide = {1'b0, a} + {1'b0, b} + {{DATA_WIDTH{1'b0}}, cin};
      sum  = wide[DATA_WIDTH-1:0];
      return {((a[31] ^ sum[31]) & (b[31] ^ sum[31])), wide};
   endfunction

   // {carry, value} of a shift by register
   function automatic logic [DATA_WIDTH:0] shift_by_amount(
      input cmd_type               kind,
      input logic [DATA_WIDTH-1:0] x,
      input logic [7:0]            amount,
      input logic                  cin
   );
      logic [DATA_WIDTH-1:0] value;
      logic [DATA_WIDTH-1:0] moved;
      logic                  c;
      int                    n;
      value = x;
      c     = cin;
      n     = int'(amount);
      if (n != 0) begin
         case (kind)
            OP_LSL: begin
               if (n < 32) begin
                  moved = x >> (32 - n);
                  c     = moved[0];
                  value = x << n;
               end else begin
                  c     = (n == 32) ? x[0] : 1'b0;
                  value = '0;
               end
            end
            OP_LSR: begin
               if (n < 32) begin
                  moved = x >> (n - 1);
                  c     = moved[0];
                  value = x >> n;
               end else begin
                  c     = (n == 32) ? x[31] : 1'b0;
                  value = '0;
               end
            end
            OP_ASR: begin
               if (n < 32) begin
                  moved = x >> (n - 1);
                  c     = moved[0];
                  value = $signed(x) >>> n;
               end else begin
                  c     = x[31];
                  value = {DATA_WIDTH{x[31]}};
               end
            end
            default: begin
               // rotate: only the low five bits move the data
               if (n % 32 != 0)
                  value = (x >> (n % 32)) | (x << (32 - n % 32));
               c = value[31];
            end
         endcase
      end
      return {c, value};
   endfunction

   function automatic alu_outcome_t alu_execute(
      input cmd_type                cmd,
      input logic [DATA_WIDTH-1:0]  a,
      input logic [DATA_WIDTH-1:0]  b,
      input logic                   cin,
      input logic                   vin,
      input logic [INDEX_WIDTH-1:0] idx
   );
      alu_outcome_t          r;
      logic [DATA_WIDTH+1:0] sum;
      logic [DATA_WIDTH:0]   shifted;
      logic [63:0]           product;
      r.value       = '0;
      r.write_back  = 1'b1;
      r.write_index = idx;
      r.carry       = cin;
      r.overflow    = vin;
      case (cmd)
         OP_AND: r.value = a & b;
         OP_EOR: r.value = a ^ b;
         OP_LSL, OP_LSR, OP_ASR, OP_ROR: begin
            shifted = shift_by_amount(cmd, a, b[7:0], cin);
            {r.carry, r.value} = shifted;
         end
         OP_ADC: begin
            sum = add_with_flags(a, b, cin);
            {r.overflow, r.carry, r.value} = sum;
         end
         OP_SBC: begin
            sum = add_with_flags(a, ~b, cin);
            {r.overflow, r.carry, r.value} = sum;
         end
         OP_TST: begin
            r.value      = a & b;
            r.write_back = 1'b0;
         end
         OP_NEG: begin
            sum = add_with_flags('0, ~b, 1'b1);
            {r.overflow, r.carry, r.value} = sum;
         end
         OP_CMP: begin
            sum = add_with_flags(a, ~b, 1'b1);
            {r.overflow, r.carry, r.value} = sum;
            r.write_back = 1'b0;
         end
         OP_CMN: begin
            sum = add_with_flags(a, b, 1'b0);
            {r.overflow, r.carry, r.value} = sum;
            r.write_back = 1'b0;
         end
         OP_ORR: r.value = a | b;
         OP_MUL: begin
            product = {32'b0, a} * {32'b0, b};
            r.value = product[DATA_WIDTH-1:0];
         end
         OP_BIC: r.value = a & ~b;
         default: r.value = ~b;
      endcase
      r.negative = r.value[31];
      r.zero     = (r.value == '0);
      return r;
   endfunction

   task automatic report_mismatch(
      input string                 field,
      input logic [DATA_WIDTH-1:0] got,
      input logic [DATA_WIDTH-1:0] want
   );
      $display("ERROR response %0d: %s is %h, should be %h", response_number, field, got, want);
      mismatch_count++;
   endtask

   initial begin
      mismatch_count    = 0;
      outstanding_count = 0;
      response_number   = 0;
   end

   always @(posedge clock) begin
      alu_outcome_t want;
      if (reset) begin
         predicted_results.delete();
         outstanding_count <= 0;
      end else begin
         if (req_valid && !req_stall)
            predicted_results.push_back(alu_execute(cmd_type'(req_command),
               req_first_operand, req_second_operand, req_carry_in,
               req_overflow_in, req_dest_index));
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("unrequested response", rsp_result_value, '0);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_result_value !== want.value)
                  report_mismatch("result_value", rsp_result_value, want.value);
               if (rsp_write_back !== want.write_back)
                  report_mismatch("write_back", 32'(rsp_write_back), 32'(want.write_back));
               if (rsp_write_index !== want.write_index)
                  report_mismatch("write_index", 32'(rsp_write_index), 32'(want.write_index));
               if (rsp_flag_negative !== want.negative)
                  report_mismatch("flag_negative", 32'(rsp_flag_negative), 32'(want.negative));
               if (rsp_flag_zero !== want.zero)
                  report_mismatch("flag_zero", 32'(rsp_flag_zero), 32'(want.zero));
               if (rsp_flag_carry !== want.carry)
                  report_mismatch("flag_carry", 32'(rsp_flag_carry), 32'(want.carry));
               if (rsp_flag_overflow !== want.overflow)
                  report_mismatch("flag_overflow", 32'(rsp_flag_overflow), 32'(want.overflow));
            end
            response_number++;
         end
         outstanding_count <= predicted_results.size();
      end
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the compressed-ISA register ALU
// Sends a directed set of instructions (every operation, operand extremes,
// the shift boundaries) and then random instructions with random gaps on
// the request side and random stalls on the response side; the checker
// module predicts and compares every response.
// ----------------------------------------------------------------------------
module tb_top;
   import tra_pkg::*;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned CHUNK_COUNT  = 14;
   localparam int unsigned CHUNK_ITEMS  = 100;
   localparam int unsigned SETTLE_TIME  = 8;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_valid          = 1'b0;
   logic                   req_stall;
   logic [3:0]             req_command        = '0;
   logic [DATA_WIDTH-1:0]  req_first_operand  = '0;
   logic [DATA_WIDTH-1:0]  req_second_operand = '0;
   logic                   req_carry_in       = 1'b0;
   logic                   req_overflow_in    = 1'b0;
   logic [INDEX_WIDTH-1:0] req_dest_index     = '0;

   logic                   rsp_valid;
   logic                   rsp_stall          = 1'b0;
   logic [DATA_WIDTH-1:0]  rsp_result_value;
   logic                   rsp_write_back;
   logic [INDEX_WIDTH-1:0] rsp_write_index;
   logic                   rsp_flag_negative;
   logic                   rsp_flag_zero;
   logic                   rsp_flag_carry;
   logic                   rsp_flag_overflow;

   int unsigned mismatch_count;
   int unsigned outstanding_count;
   int unsigned cycle_count;

   // idling switches, flipped per phase by the stimulus process
   bit sender_gaps_on   = 1'b0;
   bit receiver_stalls_on = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   thumb_register_alu_unit DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_carry_in       (req_carry_in),
      .req_overflow_in    (req_overflow_in),
      .req_dest_index     (req_dest_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_write_back     (rsp_write_back),
      .rsp_write_index    (rsp_write_index),
      .rsp_flag_negative  (rsp_flag_negative),
      .rsp_flag_zero      (rsp_flag_zero),
      .rsp_flag_carry     (rsp_flag_carry),
      .rsp_flag_overflow  (rsp_flag_overflow)
   );

   thumb_register_alu_checker alu_checker (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_first_operand  (req_first_operand),
      .req_second_operand (req_second_operand),
      .req_carry_in       (req_carry_in),
      .req_overflow_in    (req_overflow_in),
      .req_dest_index     (req_dest_index),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_value   (rsp_result_value),
      .rsp_write_back     (rsp_write_back),
      .rsp_write_index    (rsp_write_index),
      .rsp_flag_negative  (rsp_flag_negative),
      .rsp_flag_zero      (rsp_flag_zero),
      .rsp_flag_carry     (rsp_flag_carry),
      .rsp_flag_overflow  (rsp_flag_overflow),
      .mismatch_count     (mismatch_count),
      .outstanding_count  (outstanding_count)
   );

   // Present one instruction and hold it until the ALU takes it. Called at a
   // rising edge; returns at the edge where the transaction was accepted, so
   // valid stays high into the next call unless a gap is inserted.
   task automatic send_instruction(
      input cmd_type                cmd,
      input logic [DATA_WIDTH-1:0]  first,
      input logic [DATA_WIDTH-1:0]  second,
      input logic                   carry,
      input logic                   overflow,
      input logic [INDEX_WIDTH-1:0] dest
   );
      if (sender_gaps_on && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_command        <= cmd;
      req_first_operand  <= first;
      req_second_operand <= second;
      req_carry_in       <= carry;
      req_overflow_in    <= overflow;
      req_dest_index     <= dest;
      // req_stall read right after the edge is its value at that edge
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and hold off until every outstanding response has arrived.
   task automatic drain_responses();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding_count != 0);
   endtask

   // Favor the values that expose carry, overflow and zero corner cases.
   function automatic logic [DATA_WIDTH-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return 32'($urandom_range(0, 15));
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random_instruction();
      cmd_type               cmd;
      logic [DATA_WIDTH-1:0] first;
      logic [DATA_WIDTH-1:0] second;
      cmd    = cmd_type'($urandom_range(0, 15));
      first  = pick_operand();
      second = pick_operand();
      // steer most shift amounts around the 0 / 31 / 32 / 33 boundaries
      if ((cmd == OP_LSL || cmd == OP_LSR || cmd == OP_ASR || cmd == OP_ROR) &&
          $urandom_range(0, 3) != 0)
         second[7:0] = 8'($urandom_range(0, 40));
      send_instruction(cmd, first, second, 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)));
   endtask

   // Receiver side: random stall bursts while enabled.
   initial begin
      forever begin
         @(posedge clock);
         if (receiver_stalls_on && !reset && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
         @(posedge clock);
      $display("tb_top failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed part: every operation once, then the shift boundaries.
      send_instruction(OP_AND, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 1'b1, 3'd0);
      send_instruction(OP_EOR, 32'hFFFF_FFFF, 32'h5A5A_A5A5, 1'b0, 1'b0, 3'd7);
      send_instruction(OP_LSL, 32'h8000_0001, 32'hFFFF_FF00, 1'b1, 1'b0, 3'd1);
      send_instruction(OP_LSR, 32'h0000_0003, 32'h0000_0001, 1'b0, 1'b1, 3'd2);
      send_instruction(OP_ASR, 32'h8000_0000, 32'h0000_001F, 1'b0, 1'b0, 3'd3);
      send_instruction(OP_ADC, 32'hFFFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 3'd4);
      send_instruction(OP_SBC, 32'h8000_0000, 32'h0000_0001, 1'b1, 1'b0, 3'd5);
      send_instruction(OP_ROR, 32'h1234_5678, 32'h0000_0004, 1'b0, 1'b1, 3'd6);
      send_instruction(OP_TST, 32'hF0F0_F0F0, 32'h0F0F_0F0F, 1'b1, 1'b1, 3'd7);
      send_instruction(OP_NEG, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 3'd0);
      send_instruction(OP_CMP, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 1'b1, 3'd1);
      send_instruction(OP_CMN, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1, 1'b0, 3'd2);
      send_instruction(OP_ORR, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b0, 3'd3);
      send_instruction(OP_MUL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 3'd4);
      send_instruction(OP_BIC, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1'b1, 3'd5);
      send_instruction(OP_MVN, 32'h1234_5678, 32'h0000_0000, 1'b1, 1'b0, 3'd6);
      send_instruction(OP_LSL, 32'h0000_0001, 32'h0000_0020, 1'b0, 1'b0, 3'd7);
      send_instruction(OP_LSL, 32'hFFFF_FFFF, 32'h0000_0021, 1'b1, 1'b1, 3'd0);
      send_instruction(OP_LSR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0, 3'd1);
      send_instruction(OP_LSR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0, 3'd2);
      send_instruction(OP_ASR, 32'h8000_0000, 32'h0000_0020, 1'b0, 1'b0, 3'd3);
      send_instruction(OP_ASR, 32'h7FFF_FFFF, 32'h0000_00C8, 1'b1, 1'b1, 3'd4);
      send_instruction(OP_ROR, 32'h8000_0001, 32'h0000_0020, 1'b0, 1'b0, 3'd5);
      send_instruction(OP_ROR, 32'h0000_0001, 32'h0000_0040, 1'b1, 1'b0, 3'd6);
      send_instruction(OP_ROR, 32'h8765_4321, 32'hFFFF_FF00, 1'b1, 1'b1, 3'd7);

      // Pause until the directed transactions are all back.
      drain_responses();

      // Random part in phases: most idle on both sides, one calm, two idle on
      // one side only, a full drain in the middle, and a calm tail.
      for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
         sender_gaps_on     = (chunk < CHUNK_COUNT - 2) && (chunk != 4) && (chunk != 9);
         receiver_stalls_on = (chunk < CHUNK_COUNT - 2) && (chunk != 4) && (chunk != 10);
         if (chunk == 7)
            drain_responses();
         for (int n = 0; n < CHUNK_ITEMS; n++)
            send_random_instruction();
      end
      req_valid <= 1'b0;

      // Wait out the outstanding responses and the pipeline depth.
      do @(posedge clock); while (outstanding_count != 0);
      repeat (SETTLE_TIME) @(posedge clock);

      if (mismatch_count == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule

/* thumb_register_alu_unit.f */
sv/tra_pkg.sv
sv/tra_alu_core.sv
sv/thumb_register_alu_unit.sv
tb/sv/thumb_register_alu_checker.sv
tb/sv/tb_top.sv
